// ===== hdl/cma_pkg.sv =====
// Shared constants and the reciprocal table for the centered moving average.
package cma_pkg;

  // Sample width and the largest half window.
  localparam int unsigned SAMPLE_WIDTH = 16;
  localparam int unsigned MAX_HALF     = 16;

  // Largest window and the widths that follow from it.
  localparam int unsigned MAX_WINDOW = 2 * MAX_HALF + 1;
  localparam int unsigned CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int unsigned HALF_W     = $clog2(MAX_HALF + 1);
  localparam int unsigned SUM_W      = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
  localparam int unsigned ABS_W      = SUM_W - 1;

  // Prefix sum memory: a power of two deep, at least one window deep.
  localparam int unsigned ADDR_W    = $clog2(MAX_WINDOW);
  localparam int unsigned MEM_DEPTH = 1 << ADDR_W;

  // Configuration register width and saturation value of the sample count.
  localparam int unsigned CFG_W     = 6;
  localparam int unsigned SEEN_W    = 6;
  localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

  // Reciprocals are scaled by 2^RECIP_SHIFT; the table below holds
  // floor(2^22 / m) for divisors 1 to 33.
  localparam int unsigned RECIP_SHIFT = 22;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned PROD_W      = ABS_W + RECIP_W;

  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] m);
    logic [RECIP_W-1:0] r;
    case (m)
      6'd1:    r = 23'd4194304;
      6'd2:    r = 23'd2097152;
      6'd3:    r = 23'd1398101;
      6'd4:    r = 23'd1048576;
      6'd5:    r = 23'd838860;
      6'd6:    r = 23'd699050;
      6'd7:    r = 23'd599186;
      6'd8:    r = 23'd524288;
      6'd9:    r = 23'd466033;
      6'd10:   r = 23'd419430;
      6'd11:   r = 23'd381300;
      6'd12:   r = 23'd349525;
      6'd13:   r = 23'd322638;
      6'd14:   r = 23'd299593;
      6'd15:   r = 23'd279620;
      6'd16:   r = 23'd262144;
      6'd17:   r = 23'd246723;
      6'd18:   r = 23'd233016;
      6'd19:   r = 23'd220752;
      6'd20:   r = 23'd209715;
      6'd21:   r = 23'd199728;
      6'd22:   r = 23'd190650;
      6'd23:   r = 23'd182361;
      6'd24:   r = 23'd174762;
      6'd25:   r = 23'd167772;
      6'd26:   r = 23'd161319;
      6'd27:   r = 23'd155344;
      6'd28:   r = 23'd149796;
      6'd29:   r = 23'd144631;
      6'd30:   r = 23'd139810;
      6'd31:   r = 23'd135300;
      6'd32:   r = 23'd131072;
      6'd33:   r = 23'd127100;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/centered_moving_average_top.sv =====
// Centered moving average over a stream of signed samples, prefix sums in one memory.
// Path: each result passes the address, subtract, reciprocal multiply, back multiply and
// fix-up states before it reaches the output register; a stalled output holds it in fix-up.
// Input flow: an item that gives no result leaves the input free for the next item; one that
// gives results stalls the input until all are out, set by the one read port and the shared divide path.
// Reset: asynchronous, active low; window_size returns to 1, counts and sums to zero.
module centered_moving_average_top
  import cma_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration: window width.
  input  logic                           cfg_we_i,
  input  logic [CFG_W-1:0]               cfg_wdata_i,
  // Input items.
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           last_in_i,
  // Result items.
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] average_o,
  output logic                           last_out_o
);

  // Sequencer states. Each result walks through address, subtract,
  // reciprocal multiply, back multiply and fix-up.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADDR = 3'd1;
  localparam logic [2:0] S_SUB  = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_FIX  = 3'd5;

  // The memory holds, for each sample, the running sum of the sequence
  // just before that sample. The sum of the newest m samples is then the
  // running sum after the newest sample minus the entry m-1 places back.
  // Entries are read only inside the current sequence, so the memory
  // needs no clearing. All sums wrap at SUM_W bits, which is exact for
  // any difference that spans at most one full window.
  logic [SUM_W-1:0] mem [MEM_DEPTH];

  // Control state.
  logic [2:0]        state_q, state_d;
  logic [CFG_W-1:0]  ws_q;
  logic [SUM_W-1:0]  cum_q, cum_d;
  logic [ADDR_W-1:0] cur_q, cur_d;
  logic [SEEN_W-1:0] seen_q, seen_d;
  logic [SEEN_W-1:0] k_q, k_d;
  logic [HALF_W-1:0] h_q, h_d;
  logic [HALF_W-1:0] r_q, r_d;
  logic              last_q, last_d;
  logic              out_valid_q, out_valid_d;

  // Datapath registers.
  logic [SUM_W-1:0]         rd_q;
  logic [CNT_W-1:0]         m_q;
  logic [ABS_W-1:0]         abs_q;
  logic                     neg_q;
  logic [RECIP_W-1:0]       recip_q;
  logic [ABS_W-1:0]         q0_q;
  logic [ABS_W-1:0]         qm_q;
  logic [SAMPLE_WIDTH-1:0]  average_q;
  logic                     last_out_q;

  // Combinational helpers.
  logic                     in_acc;
  logic                     out_acc;
  logic                     out_space;
  logic [HALF_W-1:0]        half;
  logic [HALF_W-1:0]        seen_min_h;
  logic [ADDR_W-1:0]        wr_addr;
  logic [CNT_W-1:0]         reach;
  logic [CNT_W-1:0]         top;
  logic [ADDR_W-1:0]        rd_addr;
  logic [SUM_W-1:0]         diff;
  logic [SUM_W-1:0]         diff_abs;
  logic [PROD_W-1:0]        prod;
  logic [ABS_W+CNT_W-1:0]   qm_full;
  logic [ABS_W-1:0]         rem;
  logic [ABS_W-1:0]         q_fix;
  logic [SAMPLE_WIDTH-1:0]  q_mag;
  logic                     seq_done;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign out_space  = !out_valid_q || !out_stall_i;

  // Half window, limited to the largest supported half.
  assign half = (ws_q[CFG_W-1:1] > (CFG_W-1)'(MAX_HALF)) ? HALF_W'(MAX_HALF)
                                                         : HALF_W'(ws_q[CFG_W-1:1]);
  assign seen_min_h = (seen_q < SEEN_W'(half)) ? HALF_W'(seen_q) : half;
  assign wr_addr    = cur_q + ADDR_W'(1);

  // Span of the current result: the newest top+1 samples, where top is
  // r+h but never more than the older samples of this sequence.
  assign reach   = CNT_W'(r_q) + CNT_W'(h_q);
  assign top     = (SEEN_W'(reach) > k_q) ? CNT_W'(k_q) : reach;
  assign rd_addr = cur_q - ADDR_W'(top);

  assign diff     = cum_q - rd_q;
  assign diff_abs = diff[SUM_W-1] ? (~diff + SUM_W'(1)) : diff;

  // Reciprocal estimate is the true quotient or one short of it; the
  // remainder check adds the missing one.
  assign prod    = PROD_W'(abs_q) * PROD_W'(recip_q);
  assign qm_full = (ABS_W+CNT_W)'(q0_q) * (ABS_W+CNT_W)'(m_q);
  assign rem     = abs_q - qm_q;
  assign q_fix   = (rem >= ABS_W'(m_q)) ? (q0_q + ABS_W'(1)) : q0_q;
  assign q_mag   = q_fix[SAMPLE_WIDTH-1:0];

  // A plain item gives one result; the final item counts r down to zero.
  assign seq_done = !last_q || (r_q == '0);

  always_comb begin
    state_d     = state_q;
    cum_d       = cum_q;
    cur_d       = cur_q;
    seen_d      = seen_q;
    k_d         = k_q;
    h_d         = h_q;
    r_d         = r_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;

    if (out_acc) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cum_d  = cum_q + {{(SUM_W-SAMPLE_WIDTH){sample_i[SAMPLE_WIDTH-1]}}, sample_i};
          cur_d  = wr_addr;
          seen_d = (seen_q == SEEN_MAX) ? seen_q : (seen_q + SEEN_W'(1));
          k_d    = seen_q;
          h_d    = half;
          last_d = last_in_i;
          // The result centered h samples back is due once h older
          // samples exist; the final item flushes everything still due.
          r_d    = last_in_i ? seen_min_h : half;
          if (last_in_i || (seen_q >= SEEN_W'(half))) begin
            state_d = S_ADDR;
          end
        end
      end
      S_ADDR: state_d = S_SUB;
      S_SUB:  state_d = S_MUL1;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_FIX;
      S_FIX: begin
        if (out_space) begin
          out_valid_d = 1'b1;
          if (seq_done) begin
            state_d = S_IDLE;
            if (last_q) begin
              seen_d = '0;
              cum_d  = '0;
            end
          end else begin
            r_d     = r_q - HALF_W'(1);
            state_d = S_ADDR;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ws_q        <= CFG_W'(1);
      cum_q       <= '0;
      cur_q       <= '0;
      seen_q      <= '0;
      k_q         <= '0;
      h_q         <= '0;
      r_q         <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ws_q <= cfg_wdata_i;
      end
      state_q     <= state_d;
      cum_q       <= cum_d;
      cur_q       <= cur_d;
      seen_q      <= seen_d;
      k_q         <= k_d;
      h_q         <= h_d;
      r_q         <= r_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Prefix sum memory: one write at accept, one registered read per result.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mem[wr_addr] <= cum_q;
    end
    if (state_q == S_ADDR) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Divide path and output register.
  always_ff @(posedge clk_i) begin
    if (state_q == S_ADDR) begin
      m_q <= top + CNT_W'(1);
    end
    if (state_q == S_SUB) begin
      neg_q   <= diff[SUM_W-1];
      abs_q   <= diff_abs[ABS_W-1:0];
      recip_q <= recip(m_q);
    end
    if (state_q == S_MUL1) begin
      q0_q <= prod[RECIP_SHIFT+ABS_W-1:RECIP_SHIFT];
    end
    if (state_q == S_MUL2) begin
      qm_q <= qm_full[ABS_W-1:0];
    end
    if ((state_q == S_FIX) && out_space) begin
      average_q  <= neg_q ? (~q_mag + SAMPLE_WIDTH'(1)) : q_mag;
      last_out_q <= last_q && (r_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign average_o   = average_q;
  assign last_out_o  = last_out_q;

endmodule
